FILE: rtl/core/dmarf_pkg.sv
// Shared types, port codes and the port decoder for the dual DMA register file.
`default_nettype none

package dmarf_pkg;

    // Channel count and per-channel byte store geometry
    localparam int CHANNELS   = 8;
    localparam int CH_W       = $clog2(CHANNELS);
    localparam int MEM_AW     = 2 + CH_W + 1;
    localparam int MEM_DEPTH  = 1 << MEM_AW;
    localparam int BYTE_W     = 8;

    // Store regions inside the byte memory
    localparam logic [1:0] REGION_ADDR  = 2'd0;
    localparam logic [1:0] REGION_COUNT = 2'd1;
    localparam logic [1:0] REGION_PAGE  = 2'd2;
    localparam logic [1:0] REGION_MODE  = 2'd3;

    // Port numbers
    localparam logic [7:0] PORT_CTL1_BASE = 8'hC0;
    localparam logic [7:0] PORT_CTL1_END  = 8'hCF;
    localparam logic [7:0] PORT_CTL0_END  = 8'h07;
    localparam logic [7:0] PORT_PAGE0     = 8'h87;
    localparam logic [7:0] PORT_PAGE1     = 8'h83;
    localparam logic [7:0] PORT_PAGE2     = 8'h81;
    localparam logic [7:0] PORT_PAGE3     = 8'h82;
    localparam logic [7:0] PORT_PAGE4     = 8'h8F;
    localparam logic [7:0] PORT_PAGE5     = 8'h8B;
    localparam logic [7:0] PORT_PAGE6     = 8'h89;
    localparam logic [7:0] PORT_PAGE7     = 8'h8A;
    localparam logic [7:0] PORT_MASK0     = 8'h0A;
    localparam logic [7:0] PORT_MODE0     = 8'h0B;
    localparam logic [7:0] PORT_FF0       = 8'h0C;
    localparam logic [7:0] PORT_MRESET0   = 8'h0D;
    localparam logic [7:0] PORT_MASKRST0  = 8'h0E;
    localparam logic [7:0] PORT_MASK1     = 8'hD4;
    localparam logic [7:0] PORT_MODE1     = 8'hD6;
    localparam logic [7:0] PORT_FF1       = 8'hD8;
    localparam logic [7:0] PORT_MRESET1   = 8'hDA;
    localparam logic [7:0] PORT_MASKRST1  = 8'hDE;

    typedef enum logic [3:0] {
        KIND_NONE,
        KIND_ADDR,
        KIND_COUNT,
        KIND_PAGE,
        KIND_MASK,
        KIND_MODE,
        KIND_FF,
        KIND_MRESET,
        KIND_MASKRESET
    } access_kind_t;

    typedef struct packed {
        access_kind_t      kind;
        logic [CH_W-1:0]   chan;
        logic              ctl;
    } port_decode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_OUT
    } ctrl_state_t;

    // Map an I/O port to its access kind, channel and controller
    function automatic port_decode_t dmarf_decode(input logic [7:0] port);
        port_decode_t d;
        d.kind = KIND_NONE;
        d.chan = '0;
        d.ctl  = 1'b0;
        if (port <= PORT_CTL0_END) begin
            d.kind = port[0] ? KIND_COUNT : KIND_ADDR;
            d.chan = {1'b0, port[2:1]};
        end else if (port >= PORT_CTL1_BASE && port <= PORT_CTL1_END && !port[0]) begin
            d.kind = port[1] ? KIND_COUNT : KIND_ADDR;
            d.chan = {1'b1, port[3:2]};
            d.ctl  = 1'b1;
        end else begin
            case (port)
                PORT_PAGE0:    begin d.kind = KIND_PAGE; d.chan = 3'd0; end
                PORT_PAGE1:    begin d.kind = KIND_PAGE; d.chan = 3'd1; end
                PORT_PAGE2:    begin d.kind = KIND_PAGE; d.chan = 3'd2; end
                PORT_PAGE3:    begin d.kind = KIND_PAGE; d.chan = 3'd3; end
                PORT_PAGE4:    begin d.kind = KIND_PAGE; d.chan = 3'd4; end
                PORT_PAGE5:    begin d.kind = KIND_PAGE; d.chan = 3'd5; end
                PORT_PAGE6:    begin d.kind = KIND_PAGE; d.chan = 3'd6; end
                PORT_PAGE7:    begin d.kind = KIND_PAGE; d.chan = 3'd7; end
                PORT_MASK0:    d.kind = KIND_MASK;
                PORT_MODE0:    d.kind = KIND_MODE;
                PORT_FF0:      d.kind = KIND_FF;
                PORT_MRESET0:  d.kind = KIND_MRESET;
                PORT_MASKRST0: d.kind = KIND_MASKRESET;
                PORT_MASK1:    begin d.kind = KIND_MASK;      d.ctl = 1'b1; end
                PORT_MODE1:    begin d.kind = KIND_MODE;      d.ctl = 1'b1; end
                PORT_FF1:      begin d.kind = KIND_FF;        d.ctl = 1'b1; end
                PORT_MRESET1:  begin d.kind = KIND_MRESET;    d.ctl = 1'b1; end
                PORT_MASKRST1: begin d.kind = KIND_MASKRESET; d.ctl = 1'b1; end
                default:       d.kind = KIND_NONE;
            endcase
        end
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dmarf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dmarf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/dual_dma_controller_register_file_core.sv
// Top level of the dual DMA controller register file: decode, byte store, masks.
//
//  channel | signals                                    | beat
//  --------+--------------------------------------------+-------------------------
//  in      | in_valid in_ready command port_address      | one bus byte access
//          | write_data                                 |
//  out     | out_valid out_ready read_data port_hit      | one result per access
//          | mask_vector                                |
//
// Each access steps through accept in ST_IDLE, the registered read of the byte
// store in ST_READ, and then the result beat in ST_OUT. The next access
// is taken once the result beat has left. A stalled result holds the block.
// Reset clears the masks to all ones, the byte pointers and the store's valid
// bits; an unwritten store byte reads as zero, so no clearing pass is needed.
`default_nettype none

module dual_dma_controller_register_file_core
    import dmarf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       command,
    input  wire logic [7:0] port_address,
    input  wire logic [7:0] write_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [7:0] read_data,
    output logic            port_hit,
    output logic      [CHANNELS-1:0] mask_vector
);

    ctrl_state_t state_reg, state_next;

    logic [CHANNELS-1:0]  masks_reg, masks_next;
    logic [1:0]           ptr_reg, ptr_next;
    logic [MEM_DEPTH-1:0] valid_reg, valid_next;

    logic       use_mem_reg, use_mem_next;
    logic       hit_reg, hit_next;
    logic       entry_valid_reg, entry_valid_next;
    logic [7:0] rdata_reg, rdata_next;

    logic                in_beat;
    port_decode_t        dec;
    logic                ctl;
    logic                high;
    logic [1:0]          region;
    logic [CH_W-1:0]     entry_ch;
    logic [MEM_AW-1:0]   mem_addr;
    logic                mem_we;
    logic [BYTE_W-1:0]   mem_wdata;
    logic [BYTE_W-1:0]   mem_q;
    logic [CHANNELS-1:0] group;
    logic [CH_W-1:0]     mask_ch;

    assign in_beat = in_valid && in_ready;
    assign dec     = dmarf_decode(port_address);

    // Pick the controller, byte half and store entry for this access
    always_comb
    begin
        ctl       = (dec.kind == KIND_ADDR || dec.kind == KIND_COUNT) ? dec.chan[CH_W-1]
                                                                      : dec.ctl;
        high      = ptr_reg[ctl];
        group     = ctl ? {{(CHANNELS/2){1'b1}}, {(CHANNELS/2){1'b0}}}
                        : {{(CHANNELS/2){1'b0}}, {(CHANNELS/2){1'b1}}};
        mask_ch   = {ctl, write_data[1:0]};
        region    = REGION_PAGE;
        entry_ch  = dec.chan;
        mem_wdata = write_data;
        mem_we    = 1'b0;
        case (dec.kind)
            KIND_ADDR:
            begin
                region = REGION_ADDR;
                mem_we = command;
            end
            KIND_COUNT:
            begin
                region = REGION_COUNT;
                mem_we = command;
            end
            KIND_PAGE:
            begin
                region = REGION_PAGE;
                mem_we = command;
            end
            KIND_MODE:
            begin
                region    = REGION_MODE;
                entry_ch  = mask_ch;
                mem_wdata = {2'b00, write_data[7:2]};
                mem_we    = command;
            end
            default:
            begin
                region = REGION_PAGE;
            end
        endcase
        mem_addr = {region, entry_ch,
                    (dec.kind == KIND_ADDR || dec.kind == KIND_COUNT) ? high : 1'b0};
    end

    // Update masks, byte pointers and valid bits on an accepted beat
    always_comb
    begin
        masks_next = masks_reg;
        ptr_next   = ptr_reg;
        valid_next = valid_reg;
        if (in_beat)
        begin
            if (mem_we)
            begin
                valid_next[mem_addr] = 1'b1;
            end
            case (dec.kind)
                KIND_ADDR, KIND_COUNT:
                begin
                    ptr_next[ctl] = ~ptr_reg[ctl];
                end
                KIND_MASK:
                begin
                    if (command)
                    begin
                        masks_next[mask_ch] = write_data[2];
                    end
                end
                KIND_FF:
                begin
                    if (command)
                    begin
                        ptr_next[ctl] = 1'b0;
                    end
                end
                KIND_MRESET:
                begin
                    if (command)
                    begin
                        ptr_next[ctl] = 1'b0;
                        masks_next    = masks_reg | group;
                    end
                end
                KIND_MASKRESET:
                begin
                    if (command)
                    begin
                        masks_next = masks_reg & ~group;
                    end
                end
                default:
                begin
                    masks_next = masks_reg;
                end
            endcase
        end
    end

    // Capture the result context at accept, form read data after the store read
    always_comb
    begin
        use_mem_next     = use_mem_reg;
        hit_next         = hit_reg;
        entry_valid_next = entry_valid_reg;
        rdata_next       = rdata_reg;
        if (in_beat)
        begin
            use_mem_next     = !command && (dec.kind == KIND_ADDR || dec.kind == KIND_COUNT ||
                                            dec.kind == KIND_PAGE);
            hit_next         = (dec.kind != KIND_NONE);
            entry_valid_next = valid_reg[mem_addr];
        end
        if (state_reg == ST_READ)
        begin
            rdata_next = (use_mem_reg && entry_valid_reg) ? mem_q : 8'h00;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready  = 1'b1;
            ST_OUT:  out_valid = 1'b1;
            default:
            begin
                in_ready  = 1'b0;
                out_valid = 1'b0;
            end
        endcase
    end

    assign read_data   = rdata_reg;
    assign port_hit    = hit_reg;
    assign mask_vector = masks_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            masks_reg <= '1;
            ptr_reg   <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            masks_reg <= masks_next;
            ptr_reg   <= ptr_next;
            valid_reg <= valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        use_mem_reg     <= use_mem_next;
        hit_reg         <= hit_next;
        entry_valid_reg <= entry_valid_next;
        rdata_reg       <= rdata_next;
    end

    // Byte store: address, count, page and mode bytes of every channel
    dmarf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (in_beat && mem_we),
        .waddr (mem_addr),
        .wdata (mem_wdata),
        .re    (in_beat),
        .raddr (mem_addr),
        .rdata (mem_q)
    );

endmodule

`default_nettype wire

FILE: rtl/core/dmarf_checker.sv
// Port-level checks for the dual DMA register file, bound to the top level.
`default_nettype none

module dmarf_port_checks
    import dmarf_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                command,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic [7:0]          read_data,
    input wire logic                port_hit,
    input wire logic [CHANNELS-1:0] mask_vector
);

    // A stalled result beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data) &&
                                    $stable(port_hit) && $stable(mask_vector))
        else $error("result beat changed while stalled");

    // One access at a time: no new beat right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an access is in flight");

    // No input accepted while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while result pending");

    // A write returns its result beat after the ST_READ step, with zero data
    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command |-> ##2 out_valid && read_data == 8'h00)
        else $error("write access returned nonzero data or late result");

    // Undecoded ports read as zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !port_hit |-> read_data == 8'h00)
        else $error("undecoded port returned data");

endmodule

bind dual_dma_controller_register_file_core dmarf_port_checks u_dmarf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .port_hit     (port_hit),
    .mask_vector  (mask_vector)
);

`default_nettype wire
